### src/assert_macros.svh
// Assertion macros shared by the timer table modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check that expr never holds
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_ALWAYS(label, !(expr), msg)

// check that cond implies expr on the next edge
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### src/pstt_pkg.sv
// Types and codes shared by the periodic service timer table
package pstt_pkg;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_REGISTER   = 2'd1;
    localparam logic [1:0] OP_UNREGISTER = 2'd2;
    localparam logic [1:0] OP_READ       = 2'd3;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_FULL         = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT     = 2'd2;
    localparam logic [1:0] ST_BAD_INTERVAL = 2'd3;

    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] interval;
        logic [3:0]  slot;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  channel;
        logic [1:0]  status;
        logic [31:0] time_res;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic tick_start;
        logic reg_write;
        logic unreg_read;
        logic unreg_move;
        logic walk;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       reg_ok;
        logic       unreg_ok;
        logic       count_zero;
        logic       walk_last;
        logic       out_free;
    } ctrl_sts_t;

endpackage

### src/pstt_ram.sv
// Generic single-write, single-read RAM with registered read data
module pstt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### src/pstt_ctrl.sv
// Controller state machine for the periodic service timer table
`include "assert_macros.svh"

module pstt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  pstt_pkg::ctrl_sts_t  sts,
    output pstt_pkg::ctrl_cmd_t  cmd
);
    import pstt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_UMOVE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_FINISH;
                unique case (sts.op)
                    OP_TICK:
                    begin
                        cmd.tick_start = 1'b1;
                        if (!sts.count_zero)
                        begin
                            state_next = S_WALK;
                        end
                    end
                    OP_REGISTER:
                    begin
                        cmd.reg_write = sts.reg_ok;
                    end
                    OP_UNREGISTER:
                    begin
                        if (sts.unreg_ok)
                        begin
                            cmd.unreg_read = 1'b1;
                            state_next     = S_UMOVE;
                        end
                    end
                    OP_READ:
                    begin
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_UMOVE:
            begin
                cmd.unreg_move = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEVER(a_walk_empty, state_reg == S_WALK && sts.count_zero, "walk over empty table")
    `ASSERT_NEXT(a_move_after_read, cmd.unreg_read, state_reg == S_UMOVE, "move did not follow read")
endmodule

### src/pstt_dp.sv
// Datapath of the periodic service timer table: channel RAM, counters, result register
`include "assert_macros.svh"

module pstt_dp #(
    parameter int MAX_SERVICES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pstt_pkg::ctrl_cmd_t  cmd,
    output pstt_pkg::ctrl_sts_t  sts,
    input  pstt_pkg::in_item_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output pstt_pkg::out_item_t  rsp
);
    import pstt_pkg::*;

    localparam int IDX_W = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
    localparam int CNT_W = $clog2(MAX_SERVICES + 1);
    localparam int W     = (CNT_W > 4) ? CNT_W : 4;

    in_item_t           item_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [31:0]        tick_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [1:0]         res_status_reg;
    logic [3:0]         res_chan_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [63:0]        wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [63:0]        rd_data;

    logic [31:0]        rd_reload;
    logic [31:0]        cd_dec;
    logic               fire;
    logic               out_free;
    logic               walk_go;
    logic [CNT_W-1:0]   last_idx;
    logic [W-1:0]       count_w;
    logic [W-1:0]       slot_w;
    logic [W-1:0]       idx_w;
    logic               reg_ok;
    logic               unreg_ok;
    logic [1:0]         res_status;
    logic               load_fire;
    logic               load_done;

    pstt_ram #(
        .WIDTH (64),
        .DEPTH (MAX_SERVICES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_reload = rd_data[63:32];
    assign cd_dec    = rd_data[31:0] - 32'd1;
    assign fire      = (cd_dec == 32'd0);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign walk_go   = !fire || out_free;
    assign last_idx  = count_reg - CNT_W'(1);
    assign count_w   = W'(count_reg);
    assign slot_w    = W'(item_reg.slot);
    assign idx_w     = W'(idx_reg);
    assign reg_ok    = (item_reg.interval != 32'd0) && (count_reg != CNT_W'(MAX_SERVICES));
    assign unreg_ok  = slot_w < count_w;
    assign load_fire = cmd.walk && walk_go && fire;
    assign load_done = cmd.finish;

    always_comb
    begin
        unique case (item_reg.op)
            OP_REGISTER:
            begin
                if (item_reg.interval == 32'd0)
                begin
                    res_status = ST_BAD_INTERVAL;
                end
                else if (!reg_ok)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_status = ST_OK;
                end
            end
            OP_UNREGISTER:
            begin
                res_status = unreg_ok ? ST_OK : ST_BAD_SLOT;
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        sts.op         = item_reg.op;
        sts.reg_ok     = reg_ok;
        sts.unreg_ok   = unreg_ok;
        sts.count_zero = (count_reg == '0);
        sts.walk_last  = walk_go && (CNT_W'(idx_reg) == last_idx);
        sts.out_free   = out_free;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = {rd_reload, fire ? rd_reload : cd_dec};
        priority if (cmd.reg_write)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = {item_reg.interval, item_reg.interval};
        end
        else if (cmd.unreg_move)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_w[IDX_W-1:0];
            wr_data = rd_data;
        end
        else if (cmd.walk && walk_go)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        priority if (cmd.tick_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.unreg_read)
        begin
            rd_addr = last_idx[IDX_W-1:0];
        end
        else if (cmd.walk && walk_go)
        begin
            rd_addr = IDX_W'(idx_reg + 1'b1);
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            tick_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.tick_start)
            begin
                tick_reg <= tick_reg + 32'd1;
            end
            if (cmd.reg_write)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.unreg_move)
            begin
                count_reg <= last_idx;
            end
            if (cmd.tick_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.walk && walk_go)
            begin
                idx_reg <= IDX_W'(idx_reg + 1'b1);
            end
            if (load_fire || load_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req;
        end
        if (cmd.decode)
        begin
            res_status_reg <= res_status;
            res_chan_reg   <= (item_reg.op == OP_REGISTER && reg_ok) ? count_w[3:0] : 4'd0;
        end
        if (load_fire)
        begin
            out_reg.kind     <= KIND_FIRED;
            out_reg.channel  <= idx_w[3:0];
            out_reg.status   <= ST_OK;
            out_reg.time_res <= tick_reg;
            out_reg.last     <= 1'b0;
        end
        else if (load_done)
        begin
            out_reg.kind     <= KIND_DONE;
            out_reg.channel  <= res_chan_reg;
            out_reg.status   <= res_status_reg;
            out_reg.time_res <= tick_reg;
            out_reg.last     <= 1'b1;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_SERVICES), "active count over bound")
    `ASSERT_NEVER(a_no_overwrite, (load_fire || load_done) && out_valid_reg && rsp_stall,
        "result register overwritten while stalled")
    `ASSERT_NEVER(a_write_busy, cmd.reg_write && cmd.unreg_move, "two table writes at once")
endmodule

### src/periodic_service_timer_table.sv
// Top level of the periodic service timer table
//
//   port group  | direction | handshake            | payload
//   req         | in        | req_valid/req_stall  | op, interval, slot
//   rsp         | out       | rsp_valid/rsp_stall  | kind, channel, status, time_res, last
//
// One item at a time. Register and read pass decode and finish; unregister adds a move step
// for a valid slot. A tick walks the active channels: the walk reads, updates and writes back
// one channel RAM entry per cycle unless held, via a single read and a single write port.
// A stalled result register holds the walk at the channel that fires.
// Reset clears the channel count and the tick count; table entries need no clearing.
module periodic_service_timer_table #(
    parameter int MAX_SERVICES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  pstt_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output pstt_pkg::out_item_t rsp
);
    import pstt_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    pstt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pstt_dp #(
        .MAX_SERVICES (MAX_SERVICES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );
endmodule

### test/periodic_service_timer_table_test.sv
// Testbench for the periodic service timer table: directed, back-pressure and random items
`timescale 1ns / 100ps

module periodic_service_timer_table_test;
    import pstt_pkg::*;

    localparam int N_CHANNELS = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    in_item_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    out_item_t rsp;

    logic [31:0] chan_reload [N_CHANNELS];
    logic [31:0] chan_countdown [N_CHANNELS];
    int chan_count = 0;
    logic [31:0] tick_count = '0;
    out_item_t expected_rsp [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;
    int mismatches = 0;

    periodic_service_timer_table #(
        .MAX_SERVICES(N_CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #4 clk = ~clk;

    function automatic out_item_t make_rsp(logic kind, logic [3:0] channel,
                                           logic [1:0] status, logic last);
        out_item_t r;
        r.kind = kind;
        r.channel = channel;
        r.status = status;
        r.time_res = tick_count;
        r.last = last;
        return r;
    endfunction

    function automatic void predict_timer_op(in_item_t item);
        logic [3:0] channel;
        logic [1:0] status;
        channel = '0;
        status = ST_OK;
        case (item.op)
            OP_TICK:
            begin
                tick_count = tick_count + 32'd1;
                for (int i = 0; i < chan_count; i++)
                begin
                    chan_countdown[i] = chan_countdown[i] - 32'd1;
                    if (chan_countdown[i] == 32'd0)
                    begin
                        chan_countdown[i] = chan_reload[i];
                        expected_rsp.push_back(make_rsp(KIND_FIRED, 4'(i), ST_OK, 1'b0));
                    end
                end
            end
            OP_REGISTER:
            begin
                if (item.interval == 32'd0)
                    status = ST_BAD_INTERVAL;
                else if (chan_count >= N_CHANNELS)
                    status = ST_FULL;
                else
                begin
                    chan_reload[chan_count] = item.interval;
                    chan_countdown[chan_count] = item.interval;
                    channel = 4'(chan_count);
                    chan_count++;
                end
            end
            OP_UNREGISTER:
            begin
                if (int'(item.slot) >= chan_count)
                    status = ST_BAD_SLOT;
                else
                begin
                    chan_count--;
                    chan_reload[item.slot] = chan_reload[chan_count];
                    chan_countdown[item.slot] = chan_countdown[chan_count];
                end
            end
            default:
            begin
            end
        endcase
        expected_rsp.push_back(make_rsp(KIND_DONE, channel, status, 1'b1));
    endfunction

    task automatic send_request(in_item_t item);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predict_timer_op(item);
    endtask

    task automatic send_op(logic [1:0] op, logic [31:0] interval, logic [3:0] slot);
        in_item_t item;
        item.op = op;
        item.interval = interval;
        item.slot = slot;
        send_request(item);
    endtask

    task automatic check_rsp(out_item_t got);
        out_item_t want;
        if (expected_rsp.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: %p", got);
        end
        else
        begin
            want = expected_rsp.pop_front();
            if (got.kind !== want.kind || got.channel !== want.channel ||
                got.status !== want.status || got.time_res !== want.time_res ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_rsp(rsp);
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    task automatic test_directed_ops;
        send_op(OP_READ, 32'd0, 4'd0);
        send_op(OP_TICK, 32'd0, 4'd0);
        send_op(OP_UNREGISTER, 32'd0, 4'd0);
        send_op(OP_REGISTER, 32'd0, 4'd0);
        send_op(OP_REGISTER, 32'd1, 4'd0);
        send_op(OP_REGISTER, 32'hFFFF_FFFF, 4'hF);
        send_op(OP_REGISTER, 32'd2, 4'd0);
        send_op(OP_TICK, 32'hFFFF_FFFF, 4'hF);
        send_op(OP_UNREGISTER, 32'd0, 4'd0);
        send_op(OP_UNREGISTER, 32'd0, 4'd1);
        for (int i = 0; i < N_CHANNELS - 1; i++)
            send_op(OP_REGISTER, 32'd1, 4'(i));
        send_op(OP_REGISTER, 32'd7, 4'd0);
        send_op(OP_REGISTER, 32'd0, 4'd0);
        send_op(OP_TICK, 32'd0, 4'd0);
        send_op(OP_UNREGISTER, 32'd0, 4'hF);
        send_op(OP_READ, 32'hFFFF_FFFF, 4'hF);
    endtask

    task automatic test_random(int n_items, int tx_pct, int rx_pct);
        int pick;
        logic [31:0] interval;
        logic [3:0] slot;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(99);
            interval = $urandom();
            slot = 4'($urandom_range(15));
            if (pick < 40)
                send_op(OP_TICK, interval, slot);
            else if (pick < 70)
            begin
                case ($urandom_range(9))
                    0: interval = 32'd0;
                    1: interval = $urandom();
                    default: interval = $urandom_range(6, 1);
                endcase
                send_op(OP_REGISTER, interval, slot);
            end
            else if (pick < 90)
            begin
                if (chan_count > 0 && $urandom_range(3) != 0)
                    slot = 4'($urandom_range(chan_count - 1));
                send_op(OP_UNREGISTER, interval, slot);
            end
            else
                send_op(OP_READ, interval, slot);
        end
    endtask

    task automatic test_backpressure;
        send_op(OP_REGISTER, 32'd1, 4'd0);
        send_op(OP_REGISTER, 32'd1, 4'd0);
        @(posedge clk);
        hold_cycles = 300;
        for (int i = 0; i < 12; i++)
            send_op(OP_TICK, 32'd0, 4'd0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 26;
        rx_idle_pct = 60;
        test_directed_ops;
        test_random(35, 26, 60);
        test_backpressure;
        test_random(35, 60, 26);
        test_random(35, 0, 0);
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
